@@ rtl/cbv_pkg.sv @@
package cbv_pkg;

  localparam int LENGTH_BITS   = 24;
  localparam int HEADER_BYTES  = 20;
  localparam int CRC_FIELD_POS = 16;

  localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
  localparam logic [31:0] CRC_ALL_ONES = 32'hFFFFFFFF;

  localparam logic [31:0] RESET_MAGIC       = 32'd827609666;
  localparam logic [15:0] RESET_VERSION     = 16'd1;
  localparam logic [15:0] RESET_RECORD_SIZE = 16'd219;
  localparam logic [7:0]  RESET_MAX_RECORDS = 8'd255;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_SHORT       = 3'd1,
    ST_MAGIC       = 3'd2,
    ST_VERSION     = 3'd3,
    ST_RECORD_SIZE = 3'd4,
    ST_COUNT       = 3'd5,
    ST_LENGTH      = 3'd6,
    ST_CRC         = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    CFG_MAGIC       = 2'd0,
    CFG_VERSION     = 2'd1,
    CFG_RECORD_SIZE = 2'd2,
    CFG_MAX_RECORDS = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  record_count;
    logic [31:0] revision;
    logic [15:0] seed_value;
  } result_t;

endpackage

@@ rtl/crc_checked_blob_validator_unit.sv @@
// result_valid rises after the last byte of a blob passes the input register and then
// the result register; throughput: one byte per cycle, set by the combinational crc
// byte step, except that a last byte waits while a full result register is stalled
// reset (rst, synchronous): configuration registers return to their defaults, the crc
// to all ones, the byte counter and header capture clear, both pipeline slots go empty
module crc_checked_blob_validator_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  cbv_pkg::item_t       item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output cbv_pkg::result_t     result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  cbv_pkg::cfg_index_t  cfg_index,
  input  logic [31:0]          cfg_data
);
  import cbv_pkg::*;

  localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

  logic [31:0] expected_magic;
  logic [15:0] expected_version;
  logic [15:0] expected_record_size;
  logic [7:0]  max_records;

  item_t item_q;
  logic  item_q_valid;
  logic  consume;
  logic  accept;

  logic [LENGTH_BITS-1:0] byte_counter, byte_counter_next;
  logic [31:0] crc_register, crc_next;
  logic [31:0] header_magic, header_magic_next;
  logic [15:0] header_version, header_version_next;
  logic [15:0] header_record_size, header_record_size_next;
  logic [31:0] header_revision, header_revision_next;
  logic [15:0] header_count, header_count_next;
  logic [15:0] header_seed, header_seed_next;
  logic [31:0] header_crc, header_crc_next;
  logic [31:0] product;
  logic [31:0] expect_len;
  logic [7:0]  hash_byte;
  logic        in_header;
  status_t     status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_magic       <= RESET_MAGIC;
      expected_version     <= RESET_VERSION;
      expected_record_size <= RESET_RECORD_SIZE;
      max_records          <= RESET_MAX_RECORDS;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAGIC:       expected_magic       <= cfg_data;
        CFG_VERSION:     expected_version     <= cfg_data[15:0];
        CFG_RECORD_SIZE: expected_record_size <= cfg_data[15:0];
        CFG_MAX_RECORDS: max_records          <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // a last byte waits only while the result register is full and stalled
  assign consume    = item_q_valid && !(item_q.last_byte && result_valid && result_stall);
  assign item_stall = item_q_valid && !consume;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (accept) begin
      item_q_valid <= 1'b1;
    end else if (consume) begin
      item_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
    end
  end

  assign in_header = byte_counter < LENGTH_BITS'(HEADER_BYTES);
  // stored crc field goes through the crc as zero bytes
  assign hash_byte = (in_header && byte_counter >= LENGTH_BITS'(CRC_FIELD_POS)) ?
                     8'd0 : item_q.data_byte;

  cbv_crc_byte u_crc (
    .crc_in  (crc_register),
    .data    (hash_byte),
    .crc_out (crc_next)
  );

  assign byte_counter_next = (byte_counter == COUNT_MAX) ? byte_counter :
                             byte_counter + LENGTH_BITS'(1);

  always_comb begin
    header_magic_next       = header_magic;
    header_version_next     = header_version;
    header_record_size_next = header_record_size;
    header_revision_next    = header_revision;
    header_count_next       = header_count;
    header_seed_next        = header_seed;
    header_crc_next         = header_crc;
    if (in_header) begin
      case (byte_counter[4:0])
        5'd0:  header_magic_next[7:0]         = item_q.data_byte;
        5'd1:  header_magic_next[15:8]        = item_q.data_byte;
        5'd2:  header_magic_next[23:16]       = item_q.data_byte;
        5'd3:  header_magic_next[31:24]       = item_q.data_byte;
        5'd4:  header_version_next[7:0]       = item_q.data_byte;
        5'd5:  header_version_next[15:8]      = item_q.data_byte;
        5'd6:  header_record_size_next[7:0]   = item_q.data_byte;
        5'd7:  header_record_size_next[15:8]  = item_q.data_byte;
        5'd8:  header_revision_next[7:0]      = item_q.data_byte;
        5'd9:  header_revision_next[15:8]     = item_q.data_byte;
        5'd10: header_revision_next[23:16]    = item_q.data_byte;
        5'd11: header_revision_next[31:24]    = item_q.data_byte;
        5'd12: header_count_next[7:0]         = item_q.data_byte;
        5'd13: header_count_next[15:8]        = item_q.data_byte;
        5'd14: header_seed_next[7:0]          = item_q.data_byte;
        5'd15: header_seed_next[15:8]         = item_q.data_byte;
        5'd16: header_crc_next[7:0]           = item_q.data_byte;
        5'd17: header_crc_next[15:8]          = item_q.data_byte;
        5'd18: header_crc_next[23:16]         = item_q.data_byte;
        5'd19: header_crc_next[31:24]         = item_q.data_byte;
        default: ;
      endcase
    end
  end

  // count and record size settle by byte 13, long before a full header ends
  always_ff @(posedge clk) begin
    product <= header_count * header_record_size;
  end

  assign expect_len = 32'(HEADER_BYTES) + product;

  always_comb begin
    if (byte_counter_next < LENGTH_BITS'(HEADER_BYTES)) begin
      status = ST_SHORT;
    end else if (header_magic_next != expected_magic) begin
      status = ST_MAGIC;
    end else if (header_version_next != expected_version) begin
      status = ST_VERSION;
    end else if (header_record_size_next != expected_record_size) begin
      status = ST_RECORD_SIZE;
    end else if (header_count_next > {8'd0, max_records}) begin
      status = ST_COUNT;
    end else if (32'(byte_counter_next) != expect_len) begin
      status = ST_LENGTH;
    end else if (~crc_next != header_crc_next) begin
      status = ST_CRC;
    end else begin
      status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (consume && item_q.last_byte)) begin
      byte_counter       <= '0;
      crc_register       <= CRC_ALL_ONES;
      header_magic       <= '0;
      header_version     <= '0;
      header_record_size <= '0;
      header_revision    <= '0;
      header_count       <= '0;
      header_seed        <= '0;
      header_crc         <= '0;
    end else if (consume) begin
      byte_counter       <= byte_counter_next;
      crc_register       <= crc_next;
      header_magic       <= header_magic_next;
      header_version     <= header_version_next;
      header_record_size <= header_record_size_next;
      header_revision    <= header_revision_next;
      header_count       <= header_count_next;
      header_seed        <= header_seed_next;
      header_crc         <= header_crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (consume && item_q.last_byte) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && item_q.last_byte) begin
      result.status <= status;
      if (status == ST_OK) begin
        result.record_count <= header_count_next[7:0];
        result.revision     <= header_revision_next;
        result.seed_value   <= header_seed_next;
      end else begin
        result.record_count <= '0;
        result.revision     <= '0;
        result.seed_value   <= '0;
      end
    end
  end

endmodule

@@ rtl/cbv_crc_byte.sv @@
module cbv_crc_byte (
  input  logic [31:0] crc_in,
  input  logic [7:0]  data,
  output logic [31:0] crc_out
);
  import cbv_pkg::*;

  // reflected crc, eight bit steps per byte
  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    crc_out = c;
  end

endmodule

@@ tb/sv/crc_checked_blob_validator_unit_test.sv @@
`timescale 1ns / 100ps

module crc_checked_blob_validator_unit_test;
  import cbv_pkg::*;

  typedef enum logic [3:0] {
    BLOB_GOOD,
    BLOB_SHORT,
    BLOB_MAGIC,
    BLOB_VERSION,
    BLOB_RSIZE,
    BLOB_COUNT,
    BLOB_LENGTH,
    BLOB_CRC,
    BLOB_NOISE
  } blob_kind_t;

  // len is the whole blob for short and noise blobs, else the payload after the header
  typedef struct packed {
    blob_kind_t  kind;
    logic [15:0] len;
    logic [15:0] count;
    logic [31:0] flip;
    logic [31:0] rev;
    logic [15:0] seed;
    logic        typed;
    status_t     status;
  } blob_row_t;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 8;
  localparam int PHASE_BYTES = 95;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  item_t       item;
  logic        result_valid;
  logic        result_stall;
  result_t     result;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_index_t  cfg_index;
  logic [31:0] cfg_data;

  crc_checked_blob_validator_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // register copies
  logic [31:0] reg_magic;
  logic [15:0] reg_version;
  logic [15:0] reg_rsize;
  logic [7:0]  reg_max_records;

  // blob in progress
  logic [LENGTH_BITS-1:0] seen_count;
  logic [31:0]            run_crc;
  logic [31:0]            hdr_magic;
  logic [15:0]            hdr_version;
  logic [15:0]            hdr_rsize;
  logic [31:0]            hdr_revision;
  logic [15:0]            hdr_count;
  logic [15:0]            hdr_seed;
  logic [31:0]            hdr_crc;

  result_t     awaited_results [$];
  result_t     want;
  result_t     typed_result;
  logic [7:0]  blob_bytes [$];
  int          mismatches;
  int          cycle_count;
  int unsigned bytes_sent;
  bit          idle_on;
  bit          hold_req;
  bit          use_typed;

  blob_row_t directed_rows [19] = '{
    '{BLOB_SHORT,   16'd1,   16'd0,     32'h0,        32'h0,        16'h0,    1'b1, ST_SHORT},
    '{BLOB_SHORT,   16'd19,  16'd0,     32'h0,        32'h0,        16'h0,    1'b1, ST_SHORT},
    '{BLOB_GOOD,    16'd0,   16'd0,     32'h0,        32'hFFFFFFFF, 16'hFFFF, 1'b1, ST_OK},
    '{BLOB_GOOD,    16'd0,   16'd0,     32'h0,        32'h0,        16'h0,    1'b1, ST_OK},
    '{BLOB_GOOD,    16'd219, 16'd1,     32'h0,        32'h12345678, 16'hA5A5, 1'b1, ST_OK},
    '{BLOB_MAGIC,   16'd0,   16'd0,     32'h00000010, 32'h0,        16'h0,    1'b1, ST_MAGIC},
    '{BLOB_MAGIC,   16'd0,   16'd0,     32'hFFFFFFFF, 32'h0,        16'h0,    1'b1, ST_MAGIC},
    '{BLOB_VERSION, 16'd0,   16'd0,     32'h00000001, 32'h0,        16'h0,    1'b1, ST_VERSION},
    '{BLOB_VERSION, 16'd0,   16'd0,     32'h0000FFFF, 32'h0,        16'h0,    1'b1, ST_VERSION},
    '{BLOB_RSIZE,   16'd0,   16'd0,     32'h000000FF, 32'h0,        16'h0,    1'b1, ST_RECORD_SIZE},
    '{BLOB_COUNT,   16'd0,   16'd256,   32'h0,        32'h0,        16'h0,    1'b1, ST_COUNT},
    '{BLOB_COUNT,   16'd3,   16'd65535, 32'h0,        32'h0,        16'h0,    1'b1, ST_COUNT},
    '{BLOB_LENGTH,  16'd1,   16'd0,     32'h0,        32'h0,        16'h0,    1'b1, ST_LENGTH},
    '{BLOB_LENGTH,  16'd0,   16'd255,   32'h0,        32'h0,        16'h0,    1'b1, ST_LENGTH},
    '{BLOB_LENGTH,  16'd218, 16'd1,     32'h0,        32'h0,        16'h0,    1'b1, ST_LENGTH},
    '{BLOB_CRC,     16'd0,   16'd0,     32'h00000001, 32'h0,        16'h0,    1'b1, ST_CRC},
    '{BLOB_CRC,     16'd0,   16'd0,     32'h80000000, 32'h0,        16'h0,    1'b1, ST_CRC},
    '{BLOB_NOISE,   16'd30,  16'd0,     32'h0,        32'h0,        16'h0,    1'b0, ST_OK},
    '{BLOB_NOISE,   16'd24,  16'd0,     32'h0,        32'h0,        16'h0,    1'b0, ST_OK}
  };

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] crc_byte_step(input logic [31:0] c, input logic [7:0] b);
    c = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic void clear_blob_state();
    seen_count   = '0;
    run_crc      = CRC_ALL_ONES;
    hdr_magic    = '0;
    hdr_version  = '0;
    hdr_rsize    = '0;
    hdr_revision = '0;
    hdr_count    = '0;
    hdr_seed     = '0;
    hdr_crc      = '0;
  endfunction

  // advances the blob state by one byte; returns 1 with the status on the last byte
  function automatic bit validate_byte(input logic [7:0] b, input logic last,
                                       output result_t r);
    logic [LENGTH_BITS-1:0] pos;
    logic [63:0]            want_len;
    status_t                st;
    pos = seen_count;
    r = '0;
    if (pos < 4) hdr_magic[pos[1:0]*8 +: 8] = b;
    else if (pos < 6) hdr_version[pos[0]*8 +: 8] = b;
    else if (pos < 8) hdr_rsize[pos[0]*8 +: 8] = b;
    else if (pos < 12) hdr_revision[pos[1:0]*8 +: 8] = b;
    else if (pos < 14) hdr_count[pos[0]*8 +: 8] = b;
    else if (pos < 16) hdr_seed[pos[0]*8 +: 8] = b;
    else if (pos < HEADER_BYTES) hdr_crc[pos[1:0]*8 +: 8] = b;
    // stored crc field is hashed as zeros
    run_crc = crc_byte_step(run_crc,
                            (pos >= CRC_FIELD_POS && pos < HEADER_BYTES) ? 8'd0 : b);
    if (!(&seen_count)) seen_count = seen_count + 1'b1;
    if (!last) return 1'b0;
    want_len = 64'(HEADER_BYTES) + 64'(hdr_count) * 64'(hdr_rsize);
    if (seen_count < HEADER_BYTES) st = ST_SHORT;
    else if (hdr_magic != reg_magic) st = ST_MAGIC;
    else if (hdr_version != reg_version) st = ST_VERSION;
    else if (hdr_rsize != reg_rsize) st = ST_RECORD_SIZE;
    else if (hdr_count > {8'd0, reg_max_records}) st = ST_COUNT;
    else if (64'(seen_count) != want_len) st = ST_LENGTH;
    else if (~run_crc != hdr_crc) st = ST_CRC;
    else st = ST_OK;
    r.status = st;
    if (st == ST_OK) begin
      r.record_count = hdr_count[7:0];
      r.revision     = hdr_revision;
      r.seed_value   = hdr_seed;
    end
    clear_blob_state();
    return 1'b1;
  endfunction

  // magic, version and record size follow the current registers except the one the kind breaks
  function automatic void build_blob(input blob_kind_t kind, input int unsigned len,
                                     input logic [15:0] count, input logic [31:0] flip,
                                     input logic [31:0] rev, input logic [15:0] seed);
    logic [31:0] magic;
    logic [31:0] crc;
    logic [15:0] version;
    logic [15:0] rsize;
    blob_bytes.delete();
    if (kind == BLOB_SHORT || kind == BLOB_NOISE) begin
      repeat (len) blob_bytes.push_back(8'($urandom));
      return;
    end
    magic   = reg_magic ^ ((kind == BLOB_MAGIC) ? flip : 32'd0);
    version = reg_version ^ ((kind == BLOB_VERSION) ? flip[15:0] : 16'd0);
    rsize   = reg_rsize ^ ((kind == BLOB_RSIZE) ? flip[15:0] : 16'd0);
    for (int i = 0; i < 4; i++) blob_bytes.push_back(magic[8*i +: 8]);
    for (int i = 0; i < 2; i++) blob_bytes.push_back(version[8*i +: 8]);
    for (int i = 0; i < 2; i++) blob_bytes.push_back(rsize[8*i +: 8]);
    for (int i = 0; i < 4; i++) blob_bytes.push_back(rev[8*i +: 8]);
    for (int i = 0; i < 2; i++) blob_bytes.push_back(count[8*i +: 8]);
    for (int i = 0; i < 2; i++) blob_bytes.push_back(seed[8*i +: 8]);
    repeat (4) blob_bytes.push_back(8'd0);
    repeat (len) blob_bytes.push_back(8'($urandom));
    crc = CRC_ALL_ONES;
    foreach (blob_bytes[i])
      crc = crc_byte_step(crc, (i >= CRC_FIELD_POS && i < HEADER_BYTES) ? 8'd0 : blob_bytes[i]);
    crc = ~crc ^ ((kind == BLOB_CRC) ? flip : 32'd0);
    for (int i = 0; i < 4; i++) blob_bytes[CRC_FIELD_POS + i] = crc[8*i +: 8];
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic last);
    result_t r;
    int      gap;
    if (idle_on && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    @(negedge clk);
    item_valid <= 1'b1;
    item       <= '{data_byte: b, last_byte: last};
    @(posedge clk);
    while (item_stall) @(posedge clk);
    bytes_sent++;
    if (validate_byte(b, last, r)) awaited_results.push_back(use_typed ? typed_result : r);
  endtask

  task automatic send_blob();
    foreach (blob_bytes[i]) push_byte(blob_bytes[i], i == blob_bytes.size() - 1);
  endtask

  task automatic random_blob();
    int unsigned pick;
    int unsigned lim;
    int unsigned count;
    int unsigned len;
    logic [31:0] flip;
    blob_kind_t  kind;
    pick  = $urandom_range(0, 99);
    lim   = 100 / reg_rsize;
    if (lim > reg_max_records) lim = reg_max_records;
    count = $urandom_range(0, lim);
    len   = count * reg_rsize;
    // always a bit set in the low half so a 16-bit field also changes
    flip  = $urandom | (32'd1 << $urandom_range(0, 15));
    if (pick < 45) kind = BLOB_GOOD;
    else if (pick < 55) kind = BLOB_CRC;
    else if (pick < 65) begin
      kind  = BLOB_LENGTH;
      count = $urandom_range(0, reg_max_records);
      len   = $urandom_range(0, 40);
    end else if (pick < 70) kind = BLOB_MAGIC;
    else if (pick < 75) kind = BLOB_VERSION;
    else if (pick < 80) kind = BLOB_RSIZE;
    else if (pick < 85) begin
      kind  = BLOB_COUNT;
      count = $urandom_range(reg_max_records + 1, 65535);
      len   = $urandom_range(0, 8);
    end else if (pick < 95) begin
      kind = BLOB_SHORT;
      len  = $urandom_range(1, 19);
    end else begin
      kind = BLOB_NOISE;
      len  = $urandom_range(1, 48);
    end
    build_blob(kind, len, count[15:0], flip, $urandom, 16'($urandom));
    send_blob();
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MAGIC:       reg_magic       = val;
      CFG_VERSION:     reg_version     = val[15:0];
      CFG_RECORD_SIZE: reg_rsize       = val[15:0];
      CFG_MAX_RECORDS: reg_max_records = val[7:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_results();
    @(negedge clk);
    item_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_phase(input int p);
    logic [31:0] m;
    logic [15:0] v;
    logic [15:0] s;
    logic [7:0]  mx;
    case (p)
      0: begin
        m = 32'h0; v = 16'h0; s = 16'd1; mx = 8'd0;
      end
      1: begin
        m = 32'hFFFFFFFF; v = 16'hFFFF; s = 16'hFFFF; mx = 8'hFF;
      end
      2: begin
        m = 32'h31545252; v = 16'd7; s = 16'd3; mx = 8'd10;
      end
      default: begin
        m  = $urandom;
        v  = 16'($urandom);
        s  = 16'($urandom_range(1, 6));
        mx = 8'($urandom);
      end
    endcase
    write_reg(CFG_MAGIC, m);
    write_reg(CFG_VERSION, {16'd0, v});
    write_reg(CFG_RECORD_SIZE, {16'd0, s});
    write_reg(CFG_MAX_RECORDS, {24'd0, mx});
  endtask

  // receiver side: short random stalls, or one long hold-off on request
  initial begin
    int n;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_stall <= 1'b1;
        n = 0;
        while (n < HOLD_CYCLES) begin
          @(negedge clk);
          n++;
        end
        result_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: status %0d count %0d revision %h seed %h",
                   result.status, result.record_count, result.revision,
                   result.seed_value);
      end else begin
        want = awaited_results.pop_front();
        if (result.status !== want.status || result.record_count !== want.record_count ||
            result.revision !== want.revision ||
            result.seed_value !== want.seed_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %0d/%0d/%h/%h got %0d/%0d/%h/%h",
                     want.status, want.record_count, want.revision, want.seed_value,
                     result.status, result.record_count, result.revision,
                     result.seed_value);
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    blob_row_t   row;
    int unsigned phase_end;
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_MAGIC;
    cfg_data   = '0;
    idle_on    = 1'b1;
    hold_req   = 1'b0;
    use_typed  = 1'b0;
    mismatches = 0;
    bytes_sent = 0;
    reg_magic       = RESET_MAGIC;
    reg_version     = RESET_VERSION;
    reg_rsize       = RESET_RECORD_SIZE;
    reg_max_records = RESET_MAX_RECORDS;
    clear_blob_state();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed blobs under the reset register values
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      use_typed = row.typed;
      typed_result = '0;
      typed_result.status = row.status;
      if (row.status == ST_OK) begin
        typed_result.record_count = row.count[7:0];
        typed_result.revision     = row.rev;
        typed_result.seed_value   = row.seed;
      end
      build_blob(row.kind, row.len, row.count, row.flip, row.rev, row.seed);
      send_blob();
    end
    use_typed = 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      apply_phase(p);
      if (p == PHASES - 1) idle_on = 1'b0;
      if (p == 2) begin
        // results pile up behind the hold-off until the input backs up
        hold_req = 1'b1;
        repeat (30) begin
          build_blob(BLOB_SHORT, $urandom_range(1, 3), 16'd0, 32'd0, 32'd0, 16'd0);
          send_blob();
        end
      end
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) random_blob();
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/cbv_pkg.sv
rtl/cbv_crc_byte.sv
rtl/crc_checked_blob_validator_unit.sv
tb/sv/crc_checked_blob_validator_unit_test.sv
